/* rtl/aes128_ctr_byte_cipher_defines.svh */
// Assertion macros for the counter-mode byte cipher.
`ifndef AES128_CTR_BYTE_CIPHER_DEFINES_SVH
`define AES128_CTR_BYTE_CIPHER_DEFINES_SVH

// Assert that ante implies cons in the next cycle.
`define ACB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Assert that ante implies cons in the same cycle.
`define ACB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/acb_pkg.sv */
`default_nettype none
package acb_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] pkt_num;
		logic [31:0] src_node;
		logic        frame_start;
		logic        frame_end;
	} acb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} acb_out_t;

	// Entry of the queue between front and back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
		logic       new_block;
		logic [3:0] pos;
		logic [127:0] ctr_block;
	} acb_job_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_KEYX,
		ENG_RUN
	} acb_eng_state_t;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [11] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// SubBytes, ShiftRows and optionally MixColumns; byte 0 in bits 127:120.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[k + 4*c] = SBOX[b[k + 4*((c + k) % 4)]];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (mix) begin
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/acb_front.sv */
`default_nettype none
module acb_front import acb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire acb_in_t  in_data,
	output logic          job_valid,
	input  wire logic     job_stall,
	output acb_job_t      job
);
	logic [31:0] nonce_packet_q, nonce_node_q, block_count_q;
	logic [3:0]  byte_position_q;
	logic [31:0] np, nn, bc;
	logic [3:0]  pos;
	logic        take;

	assign in_stall  = job_stall;
	assign job_valid = in_valid;
	assign take      = in_valid && !job_stall;

	always_comb begin
		np  = in_data.frame_start ? in_data.pkt_num : nonce_packet_q;
		nn  = in_data.frame_start ? in_data.src_node : nonce_node_q;
		bc  = in_data.frame_start ? 32'd0 : block_count_q;
		pos = in_data.frame_start ? 4'd0 : byte_position_q;
		job.data_byte = in_data.data_byte;
		job.frame_end = in_data.frame_end;
		job.new_block = (pos == 4'd0);
		job.pos       = pos;
		job.ctr_block = {np[7:0], np[15:8], np[23:16], np[31:24], 32'd0,
			nn[7:0], nn[15:8], nn[23:16], nn[31:24], bc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonce_packet_q  <= '0;
			nonce_node_q    <= '0;
			block_count_q   <= '0;
			byte_position_q <= '0;
		end else if (take) begin
			nonce_packet_q  <= np;
			nonce_node_q    <= nn;
			byte_position_q <= pos + 4'd1;
			block_count_q   <= (pos == 4'd15) ? bc + 32'd1 : bc;
		end
	end
endmodule
`default_nettype wire

/* rtl/acb_queue.sv */
`default_nettype none
module acb_queue import acb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_valid,
	output logic          wr_stall,
	input  wire acb_job_t wr_data,
	output logic          rd_valid,
	input  wire logic     rd_take,
	output acb_job_t      rd_data
);
	acb_job_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (rd_take) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, rd_take};
		end
	end
endmodule
`default_nettype wire

/* rtl/acb_engine.sv */
`default_nettype none
module acb_engine import acb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      key_load,
	input  wire logic [127:0] key,
	output logic           key_busy,
	input  wire logic      job_valid,
	input  wire acb_job_t  job,
	output logic           job_take,
	output logic           out_valid,
	input  wire logic      out_stall,
	output acb_out_t       out_data
);
	logic [127:0] rk_q [11];
	logic [127:0] kx_q;
	logic [3:0]   kx_idx_q;
	logic [127:0] state_q, ks_q;
	logic [3:0]   rnd_q;
	acb_eng_state_t st_q, st_d;
	logic         key_pend_q;
	logic         ks_ready_q;
	logic         out_valid_q;
	acb_out_t     out_q;
	logic [31:0]  kt;
	logic [127:0] kx_next;
	logic         out_free, byte_go, blk_start;
	logic [7:0]   ks_byte;

	// next round key from the previous one
	always_comb begin
		kt = sub_word({kx_q[23:0], kx_q[31:24]}) ^ {RCON[kx_idx_q], 24'd0};
		kx_next[127:96] = kx_q[127:96] ^ kt;
		kx_next[95:64]  = kx_q[95:64]  ^ kx_next[127:96];
		kx_next[63:32]  = kx_q[63:32]  ^ kx_next[95:64];
		kx_next[31:0]   = kx_q[31:0]   ^ kx_next[63:32];
	end

	// ks_ready_q: keystream for the head job's block is done, the byte may go
	assign out_free  = !out_valid_q || !out_stall;
	assign blk_start = (st_q == ENG_IDLE) && job_valid && job.new_block && !ks_ready_q &&
		!key_pend_q;
	assign ks_byte   = ks_q[127 - 8*job.pos -: 8];
	assign byte_go   = (st_q == ENG_IDLE) && job_valid && (!job.new_block || ks_ready_q) &&
		out_free;
	assign key_busy  = key_pend_q || (st_q == ENG_KEYX);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ENG_IDLE: begin
				if (key_pend_q) st_d = ENG_KEYX;
				else if (blk_start) st_d = ENG_RUN;
			end
			ENG_KEYX: if (kx_idx_q == 4'd10) st_d = ENG_IDLE;
			ENG_RUN:  if (rnd_q == 4'd10) st_d = ENG_IDLE;
			default:  st_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		job_take = byte_go;
	end

	always_ff @(posedge clk) begin
		if (st_q == ENG_IDLE && key_pend_q) begin
			kx_q <= key; kx_idx_q <= 4'd1; rk_q[0] <= key;
		end else if (st_q == ENG_KEYX) begin
			kx_q <= kx_next; rk_q[kx_idx_q] <= kx_next; kx_idx_q <= kx_idx_q + 4'd1;
		end
		if (blk_start) begin
			state_q <= job.ctr_block ^ rk_q[0]; rnd_q <= 4'd1;
		end else if (st_q == ENG_RUN) begin
			state_q <= aes_round(state_q, rnd_q != 4'd10) ^ rk_q[rnd_q];
			rnd_q <= rnd_q + 4'd1;
			if (rnd_q == 4'd10) ks_q <= aes_round(state_q, 1'b0) ^ rk_q[10];
		end
		if (byte_go) begin
			out_q.out_byte <= job.data_byte ^ ks_byte;
			out_q.out_last <= job.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ENG_IDLE; key_pend_q <= 1'b1; out_valid_q <= 1'b0; ks_ready_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (key_load) key_pend_q <= 1'b1;
			else if (st_q == ENG_IDLE) key_pend_q <= 1'b0;
			if (st_q == ENG_RUN && rnd_q == 4'd10) ks_ready_q <= 1'b1;
			else if (byte_go) ks_ready_q <= 1'b0;
			if (byte_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

/* rtl/aes128_ctr_byte_cipher.sv */
`default_nettype none
// AES-128 counter-mode byte cipher: each input beat's byte is XORed with the next
// keystream byte (encrypt and decrypt are the same). A beat with frame_start latches
// pkt_num/src_node and restarts the block counter. One byte per cycle within a block
// while the output is not stalled; the first byte of each 16-byte block waits for the
// iterative round unit (a load step, then one AES round per cycle). A key write
// re-expands the round keys (one round key per cycle); the expansion also runs once
// after reset. Keys sit at APB byte addresses 0x0 (key_high) and 0x8 (key_low), 64-bit
// data. A front stage tracks nonce and counter, a two-entry queue decouples it from the
// cipher engine, and the result beat is held in an output register.
module aes128_ctr_byte_cipher import acb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire acb_in_t    in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output acb_out_t        out_data,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]     prdata,
	output logic            pready
);
	`include "aes128_ctr_byte_cipher_defines.svh"

	logic [63:0] key_high_q, key_low_q;
	logic        wr_en, key_busy, fj_valid, fj_stall, q_valid, q_take;
	acb_job_t    fj, qj;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && paddr[2:0] == 3'd0;
	assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_q : key_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0; key_low_q <= '0;
		end else if (wr_en) begin
			if (paddr[3] == REG_KEY_HIGH) key_high_q <= pwdata;
			else key_low_q <= pwdata;
		end
	end

	acb_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid(fj_valid), .job_stall(fj_stall), .job(fj));

	acb_queue u_queue (.clk, .arst_n, .wr_valid(fj_valid), .wr_stall(fj_stall),
		.wr_data(fj), .rd_valid(q_valid), .rd_take(q_take), .rd_data(qj));

	acb_engine u_engine (.clk, .arst_n, .key_load(wr_en), .key({key_high_q, key_low_q}),
		.key_busy, .job_valid(q_valid), .job(qj), .job_take(q_take),
		.out_valid, .out_stall, .out_data);

	`ACB_ASSERT_NOW(a_take_needs_job, q_take, q_valid, "engine took from empty queue")
	`ACB_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(out_data),
		"stalled result changed")
	`ACB_ASSERT_NOW(a_no_take_while_key, q_take, !key_busy || qj.new_block == 1'b0,
		"byte taken with inconsistent key state")
endmodule
`default_nettype wire

/* tb/aes128_ctr_byte_cipher_tb.sv */
`default_nettype none
module aes128_ctr_byte_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import acb_pkg::*;

	localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
	localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
	localparam int N_RANDOM = 1750;

	// AES forward S-box, kept locally so the predictor stands on its own
	localparam logic [7:0] SUB_TAB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};
	localparam logic [7:0] RC_TAB [11] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	acb_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	acb_out_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	aes128_ctr_byte_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Limit: covers the slowest run, roughly 2k beats with input gaps, output stalls and block waits
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------- cipher predictor ----------------
	logic [63:0]  key_hi_m, key_lo_m;
	logic [31:0]  rk [44];
	logic [31:0]  nonce_pkt_m, nonce_node_m, blk_ctr_m;
	logic [3:0]   pos_m;
	logic [127:0] ks_m;   // keystream byte 0 in bits 127:120

	acb_out_t expected_beats [$];
	int errors = 0;
	int out_wait = 0;
	logic all_sent = 1'b0;

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SUB_TAB[w[31:24]], SUB_TAB[w[23:16]], SUB_TAB[w[15:8]], SUB_TAB[w[7:0]]};
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic expand_round_keys();
		logic [31:0] t;
		rk[0] = key_hi_m[63:32]; rk[1] = key_hi_m[31:0];
		rk[2] = key_lo_m[63:32]; rk[3] = key_lo_m[31:0];
		for (int i = 4; i < 44; i++) begin
			t = rk[i-1];
			if (i % 4 == 0)
				t = sbox_word({t[23:0], t[31:24]}) ^ {RC_TAB[i/4], 24'h0};
			rk[i] = rk[i-4] ^ t;
		end
	endtask

	function automatic logic [127:0] encrypt_ctr_block(input logic [127:0] blk);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i/4][31-8*(i%4) -: 8];
		for (int rd = 1; rd <= 10; rd++) begin
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 4; k++)
					t[k+4*c] = SUB_TAB[s[k + 4*((c+k)%4)]];
			s = t;
			if (rd < 10)
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
					s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
					s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
					s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
				end
			for (int i = 0; i < 16; i++) s[i] ^= rk[4*rd + i/4][31-8*(i%4) -: 8];
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
		return r;
	endfunction

	task automatic cipher_reset();
		key_hi_m = '0; key_lo_m = '0;
		expand_round_keys();
		nonce_pkt_m = '0; nonce_node_m = '0; blk_ctr_m = '0; pos_m = '0; ks_m = '0;
	endtask

	// Returns the beat the block should produce for one accepted input beat.
	function automatic acb_out_t cipher_byte(input acb_in_t b);
		acb_out_t o;
		if (b.frame_start) begin
			nonce_pkt_m = b.pkt_num; nonce_node_m = b.src_node;
			blk_ctr_m = '0; pos_m = '0;
		end
		if (pos_m == 0)
			ks_m = encrypt_ctr_block({nonce_pkt_m[7:0], nonce_pkt_m[15:8], nonce_pkt_m[23:16],
				nonce_pkt_m[31:24], 32'h0, nonce_node_m[7:0], nonce_node_m[15:8],
				nonce_node_m[23:16], nonce_node_m[31:24], blk_ctr_m});
		o.out_byte = b.data_byte ^ ks_m[127 - 8*pos_m -: 8];
		o.out_last = b.frame_end;
		pos_m = pos_m + 4'd1;
		if (pos_m == 0) blk_ctr_m = blk_ctr_m + 32'd1;
		return o;
	endfunction

	// ---------------- APB write ----------------
	task automatic key_write(input logic [3:0] addr, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_KEY_HIGH) key_hi_m = val; else key_lo_m = val;
		expand_round_keys();
	endtask

	// Drops valid after the last beat of a burst.
	task automatic drop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Lets the block drain and finish any key expansion before a register write.
	task automatic wait_idle();
		drop_input();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// ---------------- input driver ----------------
	// Valid stays high into the next call, so gap 0 gives back-to-back beats.
	task automatic send_beat(input acb_in_t b, input logic has_ref, input acb_out_t ref_o);
		acb_out_t p;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if ($urandom_range(0, 1)) gap = 0;  // long stretches at full rate
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		p = cipher_byte(b);
		if (has_ref && p !== ref_o) begin
			$display("%0t: table row disagrees with predictor: exp %h got %h", $time, ref_o, p);
			errors++;
		end
		expected_beats.push_back(has_ref ? ref_o : p);
	endtask

	// ---------------- output side: stall and check ----------------
	// out_wait: cycles of stall drawn after each accepted result beat
	always @(negedge clk) begin
		if (out_wait != 0) begin
			out_stall <= 1'b1;
			out_wait--;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		acb_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			out_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat: exp none got %h", $time, out_data);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (out_data.out_byte !== e.out_byte) begin
					$display("%0t: out_byte mismatch: exp %h got %h", $time, e.out_byte,
						out_data.out_byte);
					errors++;
				end
				if (out_data.out_last !== e.out_last) begin
					$display("%0t: out_last mismatch: exp %b got %b", $time, e.out_last,
						out_data.out_last);
					errors++;
				end
			end
		end
	end

	// ---------------- directed table ----------------
	typedef struct {
		acb_in_t  stim;
		logic     has_ref;
		acb_out_t ref_o;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic acb_in_t mk(input logic [7:0] d, input logic [31:0] pk,
		input logic [31:0] nd, input logic st, input logic en);
		acb_in_t b;
		b.data_byte = d; b.pkt_num = pk; b.src_node = nd;
		b.frame_start = st; b.frame_end = en;
		return b;
	endfunction

	// Frame of the given length with a valid start and end, random content and nonce.
	task automatic send_frame(input int len);
		logic [31:0] pk, nd;
		pk = $urandom(); nd = $urandom();
		for (int i = 0; i < len; i++)
			send_beat(mk(8'($urandom_range(0, 255)), pk, nd, i == 0, i == len - 1),
				1'b0, '0);
	endtask

	initial begin
		int sent;
		int len;
		cipher_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All-zero key, all-zero nonce, counter 0: keystream is AES_0(0) = 66e94bd4...
		dir_rows.push_back('{mk(8'h00, 32'h0, 32'h0, 1'b0, 1'b0), 1'b1, '{8'h66, 1'b0}});
		dir_rows.push_back('{mk(8'hff, 32'h0, 32'h0, 1'b0, 1'b1), 1'b1, '{8'h16, 1'b1}});
		// byte after frame end keeps the stream going
		dir_rows.push_back('{mk(8'h00, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0), 1'b1,
			'{8'h4b, 1'b0}});
		// restart with the same zero nonce: back to the first keystream byte
		dir_rows.push_back('{mk(8'h00, 32'h0, 32'h0, 1'b1, 1'b0), 1'b1, '{8'h66, 1'b0}});
		// extremes of the nonce, start and end on the same beat
		dir_rows.push_back('{mk(8'haa, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1), 1'b0, '0});
		dir_rows.push_back('{mk(8'h55, 32'h8000_0001, 32'h0000_0001, 1'b1, 1'b0), 1'b0, '0});
		// cross a block boundary
		for (int i = 0; i < 18; i++)
			dir_rows.push_back('{mk(i[7:0] ^ 8'h5a, 32'h0, 32'h0, 1'b0, i == 17), 1'b0, '0});
		foreach (dir_rows[i])
			send_beat(dir_rows[i].stim, dir_rows[i].has_ref, dir_rows[i].ref_o);

		// key settings: all ones, a fixed key, its low half zeroed, then random; keys change only when idle
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: begin key_write(ADDR_KEY_HIGH, '1); key_write(ADDR_KEY_LOW, '1); end
				1: begin key_write(ADDR_KEY_HIGH, 64'h2b7e1516_28aed2a6);
					key_write(ADDR_KEY_LOW, 64'habf71588_09cf4f3c); end
				2: begin key_write(ADDR_KEY_LOW, '0); end
				default: begin key_write(ADDR_KEY_HIGH, {$urandom(), $urandom()});
					key_write(ADDR_KEY_LOW, {$urandom(), $urandom()}); end
			endcase
			while (sent < (ph + 1) * N_RANDOM / 6) begin
				if ($urandom_range(0, 9) < 8) begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60)
						: $urandom_range(1, 20);
					send_frame(len);
					sent += len;
				end else begin
					// noise: bytes with random framing flags
					send_beat(mk(8'($urandom_range(0, 255)), $urandom(), $urandom(),
						$urandom_range(0, 3) == 0, 1'($urandom_range(0, 1))), 1'b0, '0);
					sent++;
				end
			end
		end
		drop_input();
		all_sent = 1'b1;
	end

	// ---------------- end of run ----------------
	initial begin
		wait (all_sent);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_beats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
